>>> design/usod_pkg.sv
// Shared types, codes and constants for the ultrasonic scan obstacle detector.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package usod_pkg;

    localparam int TIME_BITS = 32;

    localparam int ECHO_W   = 16;
    localparam int SETTLE_W = 10;
    localparam int VALID_W  = 16;
    localparam int NEAR_W   = 7;
    localparam int CFG_W    = 16;

    typedef logic signed [7:0]        cm_t;
    typedef logic [1:0]               pos_t;
    typedef logic [1:0]               code_t;
    typedef logic [1:0]               cfg_idx_t;
    typedef logic [TIME_BITS-1:0]     time_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_RIGHT = 4'b0010,
        PH_LEFT  = 4'b0100,
        PH_FRONT = 4'b1000
    } phase_t;

    localparam pos_t POS_FRONT = 2'd0;
    localparam pos_t POS_RIGHT = 2'd1;
    localparam pos_t POS_LEFT  = 2'd2;

    localparam code_t ST_FREE     = 2'd0;
    localparam code_t ST_OBSTACLE = 2'd1;
    localparam code_t ST_UNKNOWN  = 2'd2;

    localparam code_t SIDE_LEFT    = 2'd0;
    localparam code_t SIDE_RIGHT   = 2'd1;
    localparam code_t SIDE_BOTH    = 2'd2;
    localparam code_t SIDE_UNKNOWN = 2'd3;

    localparam cfg_idx_t REG_SETTLE = 2'd0;
    localparam cfg_idx_t REG_VALID  = 2'd1;
    localparam cfg_idx_t REG_NEAR   = 2'd2;

    localparam cm_t CM_UNKNOWN = -8'sd1;
    localparam logic [6:0] CM_FAR = 7'd100;
    localparam logic [ECHO_W-1:0] ECHO_MAX = 16'd2900;

    // echo / 58 for echo <= 2900: (echo * 2260) >> 17
    localparam logic [11:0] RECIP_58 = 12'd2260;
    localparam int RECIP_SHIFT = 17;

endpackage

`default_nettype wire

>>> design/ultrasonic_scan_obstacle_detector_unit.sv
// Top level: ultrasonic scan obstacle detector, one transfer per millisecond tick.
// Depends on usod_pkg.
//
//  channel  | ports                       | direction | role
//  ---------+-----------------------------+-----------+--------------------------
//  s_       | s_valid/s_ready + 8 fields  | in        | one tick of sensor data
//  m_       | m_valid/m_ready + 9 fields  | out       | one result per tick
//  cfg_     | cfg_valid/cfg_ready + index | in        | register writes, always ready
//
//  One input transfer per cycle, when s_ready; its result is registered the next cycle.
//  State and result are formed in a single pass of logic with one 12x12 multiply
//  (echo to centimeters) ahead of the output register.
//  s_ready is high while the output register is empty or being drained.
//  Reset is synchronous, active low; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_scan_obstacle_detector_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [usod_pkg::ECHO_W-1:0]   s_echo_us,
    input  wire logic                          s_ir_left_n,
    input  wire logic                          s_ir_right_n,
    input  wire logic                          s_edge_left,
    input  wire logic                          s_edge_right,
    input  wire logic                          s_scan_start,
    input  wire logic                          s_scan_report,
    input  wire logic                          s_front_query,

    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      usod_pkg::pos_t                m_servo_pos,
    output      logic                          m_trigger,
    output      logic                          m_scan_busy,
    output      usod_pkg::cm_t                 m_front_cm,
    output      usod_pkg::cm_t                 m_left_cm,
    output      usod_pkg::cm_t                 m_right_cm,
    output      usod_pkg::code_t               m_front_status,
    output      usod_pkg::code_t               m_obstacle_side,
    output      logic                          m_report_ready,

    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire usod_pkg::cfg_idx_t            cfg_index,
    input  wire logic [usod_pkg::CFG_W-1:0]    cfg_data
);

    import usod_pkg::*;

    logic [SETTLE_W-1:0] settle_cfg_reg;
    logic [VALID_W-1:0]  valid_cfg_reg;
    logic [NEAR_W-1:0]   near_cfg_reg;

    phase_t              phase_reg, phase_next;
    logic [SETTLE_W-1:0] settle_cnt_reg, settle_cnt_next;
    logic                report_pend_reg, report_pend_next;
    cm_t                 front_reg, front_next;
    cm_t                 left_reg, left_next;
    cm_t                 right_reg, right_next;
    time_t               stamp_reg, stamp_next;
    time_t               now_reg;
    pos_t                servo_reg, servo_next;

    logic                m_valid_reg;
    pos_t                servo_out_reg;
    logic                trig_reg, trig_next;
    logic                busy_reg;
    cm_t                 front_out_reg, left_out_reg, right_out_reg;
    code_t               status_reg, status_next;
    code_t               side_reg, side_next;
    logic                ready_out_reg, ready_next;

    logic [23:0]         prod;
    logic [6:0]          echo_cm;
    cm_t                 echo_dist;
    time_t               age;
    logic                stale;
    logic                ir_l, ir_r;
    logic                s_xfer;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign prod      = s_echo_us[11:0] * RECIP_58;
    assign echo_cm   = ((s_echo_us == '0) || (s_echo_us > ECHO_MAX)) ? CM_FAR
                       : prod[RECIP_SHIFT +: 7];
    assign echo_dist = cm_t'({1'b0, echo_cm});

    assign ir_l = !s_ir_left_n;
    assign ir_r = !s_ir_right_n;

    always_comb begin
        phase_next       = phase_reg;
        settle_cnt_next  = settle_cnt_reg;
        report_pend_next = report_pend_reg;
        front_next       = front_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        stamp_next       = stamp_reg;
        servo_next       = servo_reg;
        trig_next        = 1'b0;
        ready_next       = 1'b0;
        status_next      = ST_UNKNOWN;
        age              = '0;
        stale            = 1'b0;

        if (s_scan_start) begin
            phase_next       = PH_RIGHT;
            report_pend_next = s_scan_report;
            left_next        = CM_UNKNOWN;
            right_next       = CM_UNKNOWN;
            servo_next       = POS_RIGHT;
            settle_cnt_next  = settle_cfg_reg;
        end

        if (phase_next != PH_IDLE) begin
            if (settle_cnt_next == '0) begin
                trig_next = 1'b1;
                unique case (phase_next)
                    PH_RIGHT: begin
                        right_next      = echo_dist;
                        servo_next      = POS_LEFT;
                        phase_next      = PH_LEFT;
                        settle_cnt_next = settle_cfg_reg;
                    end
                    PH_LEFT: begin
                        left_next       = echo_dist;
                        servo_next      = POS_FRONT;
                        phase_next      = PH_FRONT;
                        settle_cnt_next = settle_cfg_reg;
                    end
                    default: begin
                        front_next = echo_dist;
                        stamp_next = now_reg;
                        if (report_pend_next) begin
                            ready_next       = 1'b1;
                            report_pend_next = 1'b0;
                        end
                        phase_next = PH_IDLE;
                    end
                endcase
            end else begin
                settle_cnt_next = settle_cnt_next - 1'b1;
            end
        end

        if (s_front_query) begin
            age   = now_reg - stamp_next;
            stale = age > time_t'(valid_cfg_reg);
            if (stale) begin
                if (servo_next == POS_FRONT && phase_next == PH_IDLE && !trig_next) begin
                    front_next = echo_dist;
                    stamp_next = now_reg;
                    trig_next  = 1'b1;
                end else begin
                    front_next = CM_UNKNOWN;
                end
            end
            if (ir_l || ir_r) begin
                status_next = ST_OBSTACLE;
            end else if (front_next[7]) begin
                status_next = ST_UNKNOWN;
            end else if (front_next[6:0] < near_cfg_reg) begin
                status_next = ST_OBSTACLE;
            end else begin
                status_next = ST_FREE;
            end
        end

        if (s_edge_left || s_edge_right) begin
            side_next = (s_edge_left && s_edge_right) ? SIDE_BOTH
                        : (s_edge_left ? SIDE_LEFT : SIDE_RIGHT);
        end else if (ir_l || ir_r) begin
            side_next = (ir_l && ir_r) ? SIDE_BOTH : (ir_l ? SIDE_LEFT : SIDE_RIGHT);
        end else if (left_next[7] || right_next[7]) begin
            side_next = SIDE_UNKNOWN;
        end else if (left_next == right_next) begin
            side_next = SIDE_BOTH;
        end else begin
            side_next = (left_next < right_next) ? SIDE_LEFT : SIDE_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_cfg_reg <= 10'd300;
            valid_cfg_reg  <= 16'd100;
            near_cfg_reg   <= 7'd20;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SETTLE: settle_cfg_reg <= cfg_data[SETTLE_W-1:0];
                REG_VALID:  valid_cfg_reg  <= cfg_data[VALID_W-1:0];
                REG_NEAR:   near_cfg_reg   <= cfg_data[NEAR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            settle_cnt_reg  <= '0;
            report_pend_reg <= 1'b0;
            front_reg       <= CM_UNKNOWN;
            left_reg        <= CM_UNKNOWN;
            right_reg       <= CM_UNKNOWN;
            stamp_reg       <= '0;
            now_reg         <= '0;
            servo_reg       <= POS_FRONT;
        end else if (s_xfer) begin
            phase_reg       <= phase_next;
            settle_cnt_reg  <= settle_cnt_next;
            report_pend_reg <= report_pend_next;
            front_reg       <= front_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            stamp_reg       <= stamp_next;
            now_reg         <= now_reg + 1'b1;
            servo_reg       <= servo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            servo_out_reg <= servo_next;
            trig_reg      <= trig_next;
            busy_reg      <= (phase_next != PH_IDLE);
            front_out_reg <= front_next;
            left_out_reg  <= left_next;
            right_out_reg <= right_next;
            status_reg    <= status_next;
            side_reg      <= side_next;
            ready_out_reg <= ready_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_servo_pos     = servo_out_reg;
    assign m_trigger       = trig_reg;
    assign m_scan_busy     = busy_reg;
    assign m_front_cm      = front_out_reg;
    assign m_left_cm       = left_out_reg;
    assign m_right_cm      = right_out_reg;
    assign m_front_status  = status_reg;
    assign m_obstacle_side = side_reg;
    assign m_report_ready  = ready_out_reg;

endmodule

`default_nettype wire

>>> design/usod_checker.sv
// Port-level checker for the obstacle detector top level, with its bind.
// Depends on usod_pkg and ultrasonic_scan_obstacle_detector_unit.
`timescale 1ns / 1ps
`default_nettype none

module usod_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire usod_pkg::pos_t  m_servo_pos,
    input wire logic            m_trigger,
    input wire logic            m_scan_busy,
    input wire usod_pkg::cm_t   m_left_cm,
    input wire usod_pkg::cm_t   m_right_cm,
    input wire usod_pkg::code_t m_obstacle_side,
    input wire logic            m_report_ready
);

    import usod_pkg::*;

    // hold a stalled result: valid and both side distances stay stable
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_cm) && $stable(m_right_cm))
        else $error("stalled result changed or dropped");

    // a transfer in always yields a result next cycle
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted tick produced no result");

    // a report ends the scan with a measurement at the front stop
    a_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_ready |-> m_trigger && !m_scan_busy
                                      && m_servo_pos == POS_FRONT)
        else $error("report without finished front measurement");

    // unknown side only when a side distance is unknown
    a_side_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_obstacle_side == SIDE_UNKNOWN |-> m_left_cm[7] || m_right_cm[7])
        else $error("side unknown with both distances known");

endmodule

bind ultrasonic_scan_obstacle_detector_unit usod_checker u_usod_checker (.*);

`default_nettype wire

>>> tb/sv/tb_ultrasonic_scan_obstacle_detector_unit.sv
// Self-checking bench for ultrasonic_scan_obstacle_detector_unit: directed and random ticks,
// predicted in-bench and compared field by field. Depends on usod_pkg and the top level.
`timescale 1ns / 1ps

module tb_ultrasonic_scan_obstacle_detector_unit;
    import usod_pkg::*;

    localparam int       CYCLE_LIMIT = 400000;
    localparam int       HOLD_CYCLES = 200;
    localparam int       PRINT_LIMIT = 40;
    localparam cfg_idx_t REG_NONE    = 2'd3;

    typedef struct packed {
        logic [ECHO_W-1:0] echo;
        logic              ir_left_n;
        logic              ir_right_n;
        logic              edge_left;
        logic              edge_right;
        logic              scan_start;
        logic              scan_report;
        logic              front_query;
    } sensor_tick_t;

    typedef struct packed {
        pos_t  servo;
        logic  trig;
        logic  busy;
        cm_t   front;
        cm_t   left;
        cm_t   right;
        code_t status;
        code_t side;
        logic  report;
    } distance_report_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [ECHO_W-1:0] s_echo_us = '0;
    logic              s_ir_left_n = 1'b1;
    logic              s_ir_right_n = 1'b1;
    logic              s_edge_left = 1'b0;
    logic              s_edge_right = 1'b0;
    logic              s_scan_start = 1'b0;
    logic              s_scan_report = 1'b0;
    logic              s_front_query = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pos_t              m_servo_pos;
    logic              m_trigger;
    logic              m_scan_busy;
    cm_t               m_front_cm;
    cm_t               m_left_cm;
    cm_t               m_right_cm;
    code_t             m_front_status;
    code_t             m_obstacle_side;
    logic              m_report_ready;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_idx_t          cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    ultrasonic_scan_obstacle_detector_unit dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted detector state and registers, at their reset values
    logic [SETTLE_W-1:0] cfg_settle = 10'd300;
    logic [VALID_W-1:0]  cfg_valid_ms = 16'd100;
    logic [NEAR_W-1:0]   cfg_near = 7'd20;
    phase_t              scan_phase = PH_IDLE;
    logic [SETTLE_W-1:0] settle_left = '0;
    logic                report_pending = 1'b0;
    cm_t                 front_cm = CM_UNKNOWN;
    cm_t                 left_cm = CM_UNKNOWN;
    cm_t                 right_cm = CM_UNKNOWN;
    time_t               front_stamp = '0;
    time_t               now_ms = '0;
    pos_t                servo = POS_FRONT;

    distance_report_t expected_reports[$];

    int  gap_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_count = 0;
    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  checked_count = 0;
    int  report_count = 0;
    int  trigger_count = 0;
    int  cfg_writes = 0;

    function automatic cm_t echo_cm(logic [ECHO_W-1:0] e);
        if (e == '0 || e > ECHO_MAX) return cm_t'(CM_FAR);
        return cm_t'(e / 16'd29 / 16'd2);
    endfunction

    function automatic distance_report_t advance_detector(sensor_tick_t t);
        distance_report_t r;
        cm_t              d;
        time_t            age;
        logic             trig;
        logic             ir_l;
        logic             ir_r;
        trig = 1'b0;
        r.report = 1'b0;
        ir_l = !t.ir_left_n;
        ir_r = !t.ir_right_n;
        if (t.scan_start) begin
            scan_phase = PH_RIGHT;
            report_pending = t.scan_report;
            left_cm = CM_UNKNOWN;
            right_cm = CM_UNKNOWN;
            servo = POS_RIGHT;
            settle_left = cfg_settle;
        end
        if (scan_phase != PH_IDLE) begin
            if (settle_left == '0) begin
                d = echo_cm(t.echo);
                trig = 1'b1;
                case (scan_phase)
                    PH_RIGHT: begin
                        right_cm = d;
                        servo = POS_LEFT;
                        scan_phase = PH_LEFT;
                        settle_left = cfg_settle;
                    end
                    PH_LEFT: begin
                        left_cm = d;
                        servo = POS_FRONT;
                        scan_phase = PH_FRONT;
                        settle_left = cfg_settle;
                    end
                    default: begin
                        front_cm = d;
                        front_stamp = now_ms;
                        if (report_pending) begin
                            r.report = 1'b1;
                            report_pending = 1'b0;
                        end
                        scan_phase = PH_IDLE;
                    end
                endcase
            end else begin
                settle_left = settle_left - 1'b1;
            end
        end
        r.status = ST_UNKNOWN;
        if (t.front_query) begin
            age = now_ms - front_stamp;
            if (age > cfg_valid_ms) begin
                if (servo == POS_FRONT && scan_phase == PH_IDLE && !trig) begin
                    front_cm = echo_cm(t.echo);
                    front_stamp = now_ms;
                    trig = 1'b1;
                end else begin
                    front_cm = CM_UNKNOWN;
                end
            end
            if (ir_l || ir_r) r.status = ST_OBSTACLE;
            else if (front_cm < 0) r.status = ST_UNKNOWN;
            else if (int'(front_cm) < int'(cfg_near)) r.status = ST_OBSTACLE;
            else r.status = ST_FREE;
        end
        if (t.edge_left || t.edge_right)
            r.side = (t.edge_left && t.edge_right) ? SIDE_BOTH
                   : (t.edge_left ? SIDE_LEFT : SIDE_RIGHT);
        else if (ir_l || ir_r)
            r.side = (ir_l && ir_r) ? SIDE_BOTH : (ir_l ? SIDE_LEFT : SIDE_RIGHT);
        else if (left_cm < 0 || right_cm < 0)
            r.side = SIDE_UNKNOWN;
        else if (left_cm == right_cm)
            r.side = SIDE_BOTH;
        else
            r.side = (left_cm < right_cm) ? SIDE_LEFT : SIDE_RIGHT;
        r.servo = servo;
        r.trig = trig;
        r.busy = (scan_phase != PH_IDLE);
        r.front = front_cm;
        r.left = left_cm;
        r.right = right_cm;
        now_ms = now_ms + 1'b1;
        return r;
    endfunction

    function automatic sensor_tick_t make_tick(logic [ECHO_W-1:0] echo, logic irl_n,
                                               logic irr_n, logic edl, logic edr,
                                               logic start, logic rep, logic query);
        sensor_tick_t t;
        t.echo = echo;
        t.ir_left_n = irl_n;
        t.ir_right_n = irr_n;
        t.edge_left = edl;
        t.edge_right = edr;
        t.scan_start = start;
        t.scan_report = rep;
        t.front_query = query;
        return t;
    endfunction

    function automatic sensor_tick_t random_tick();
        sensor_tick_t t;
        if ($urandom_range(9) == 0) begin
            t = sensor_tick_t'({$urandom, $urandom});
            return t;
        end
        case ($urandom_range(9))
            0: t.echo = ECHO_W'($urandom_range(65535));
            1: t.echo = '0;
            default: t.echo = ECHO_W'($urandom_range(2950));
        endcase
        t.ir_left_n = ($urandom_range(9) != 0);
        t.ir_right_n = ($urandom_range(9) != 0);
        t.edge_left = ($urandom_range(11) == 0);
        t.edge_right = ($urandom_range(11) == 0);
        t.scan_start = ($urandom_range(29) == 0);
        t.scan_report = $urandom_range(1);
        t.front_query = ($urandom_range(2) == 0);
        return t;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch on result %0d: %s expected %0d, got %0d",
                     checked_count, field, want, got);
    endtask

    // send one tick; valid stays high after the transfer unless the next call idles
    task automatic send_tick(input sensor_tick_t t);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_echo_us <= t.echo;
        s_ir_left_n <= t.ir_left_n;
        s_ir_right_n <= t.ir_right_n;
        s_edge_left <= t.edge_left;
        s_edge_right <= t.edge_right;
        s_scan_start <= t.scan_start;
        s_scan_report <= t.scan_report;
        s_front_query <= t.front_query;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_reports.push_back(advance_detector(t));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SETTLE: cfg_settle = value[SETTLE_W-1:0];
            REG_VALID:  cfg_valid_ms = value[VALID_W-1:0];
            REG_NEAR:   cfg_near = value[NEAR_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // junk above the settle and near register widths must be dropped; the unused index is ignored
    task automatic configure(input int settle, input int valid_ms, input int near);
        drain();
        write_reg(REG_SETTLE, CFG_W'(settle) | CFG_W'($urandom << SETTLE_W));
        write_reg(REG_VALID, CFG_W'(valid_ms));
        write_reg(REG_NEAR, CFG_W'(near) | CFG_W'($urandom << NEAR_W));
        write_reg(REG_NONE, CFG_W'($urandom));
    endtask

    task automatic test_reset_values();
        send_tick(make_tick(16'd1000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd1000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(16'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_echo_extremes();
        configure(0, 0, 20);
        send_tick(make_tick(16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd57, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd1159, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd1160, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd2900, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd2901, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'h5555, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'hAAAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_scan_sequence();
        // zero settle: right, left, front measured on consecutive ticks
        send_tick(make_tick(16'd580, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(16'd1160, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(16'd2320, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(16'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // restart while busy
        send_tick(make_tick(16'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(16'd600, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(16'd600, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(16'd900, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_settle_wait();
        configure(2, 65535, 100);
        send_tick(make_tick(16'd300, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_tick(make_tick(16'd300, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
        repeat (7) send_tick(make_tick(16'd1500, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_random_phase(input int count, input int gap, input int stall,
                                     input int settle, input int valid_ms, input int near,
                                     input bit pressure);
        configure(settle, valid_ms, near);
        gap_pct = gap;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            if (pressure && i == 20) hold_req = !hold_req;
            send_tick(random_tick());
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_echo_extremes();
        test_scan_sequence();
        test_settle_wait();
        test_random_phase(250, 0, 0, 0, 0, 100, 1'b0);
        test_random_phase(250, 55, 0, 3, 5, 0, 1'b0);
        test_random_phase(250, 0, 55, $urandom_range(1, 6), 65535, 20, 1'b0);
        test_random_phase(250, 31, 31, 2, $urandom_range(40), $urandom_range(100), 1'b0);
        test_random_phase(200, 0, 0, 1, 10, 50, 1'b1);
        test_random_phase(100, 0, 0, 1023, 3, 35, 1'b0);
        drain();
        repeat (10) @(posedge aclk);
        $display("Checked %0d ticks over %0d register writes: %0d measurements, %0d scan reports.",
                 checked_count, cfg_writes, trigger_count, report_count);
        $display("Idle, sender gaps, receiver stalls, a long output hold and settle 0..1023 ran.");
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_count <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        distance_report_t want;
        if (aresetn && m_valid && m_ready) begin
            checked_count++;
            if (expected_reports.size() == 0) begin
                flag_mismatch("unexpected result, servo_pos", -1, m_servo_pos);
            end else begin
                want = expected_reports.pop_front();
                if (want.report) report_count++;
                if (want.trig) trigger_count++;
                if (m_servo_pos !== want.servo)
                    flag_mismatch("servo_pos", want.servo, m_servo_pos);
                if (m_trigger !== want.trig)
                    flag_mismatch("trigger", want.trig, m_trigger);
                if (m_scan_busy !== want.busy)
                    flag_mismatch("scan_busy", want.busy, m_scan_busy);
                if (m_front_cm !== want.front)
                    flag_mismatch("front_cm", longint'(want.front), longint'(m_front_cm));
                if (m_left_cm !== want.left)
                    flag_mismatch("left_cm", longint'(want.left), longint'(m_left_cm));
                if (m_right_cm !== want.right)
                    flag_mismatch("right_cm", longint'(want.right), longint'(m_right_cm));
                if (m_front_status !== want.status)
                    flag_mismatch("front_status", want.status, m_front_status);
                if (m_obstacle_side !== want.side)
                    flag_mismatch("obstacle_side", want.side, m_obstacle_side);
                if (m_report_ready !== want.report)
                    flag_mismatch("report_ready", want.report, m_report_ready);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

>>> ultrasonic_scan_obstacle_detector_unit.f
design/usod_pkg.sv
design/ultrasonic_scan_obstacle_detector_unit.sv
design/usod_checker.sv
tb/sv/tb_ultrasonic_scan_obstacle_detector_unit.sv
